/* hw/rtl/hem_pkg.sv */
// Shared constants and types for the HDR exposure merge block.
`timescale 1ns / 1ps

package hem_pkg;

	localparam int NUM_EXP    = 4;
	localparam int SAMPLE_W   = 16;
	localparam int FRAC_W     = 16;
	localparam int SCALE_W    = 18;
	localparam int VALUE_W    = 18;
	localparam int CNT_W      = 3;
	localparam int SUM_W      = VALUE_W + $clog2(NUM_EXP);
	localparam int PROD_W     = SAMPLE_W + SCALE_W;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	// floor(x / 3) == (x * Recip3) >> Div3Shift for every x below 2^21
	localparam int RECIP_W    = 21;
	localparam int Div3Shift  = 22;
	localparam logic [RECIP_W-1:0] Recip3 = RECIP_W'((64'd1 << Div3Shift) / 3 + 1);

	localparam logic [CNT_W-1:0]    ExpReset   = CNT_W'(NUM_EXP);
	localparam logic [SAMPLE_W-1:0] LowReset   = SAMPLE_W'(131);
	localparam logic [SAMPLE_W-1:0] HighReset  = SAMPLE_W'(64880);
	localparam logic [SCALE_W-1:0]  ScaleOne   = SCALE_W'(1 << FRAC_W);

	typedef enum logic [2:0] {
		REG_EXPOSURES,
		REG_LOW_THR,
		REG_HIGH_THR,
		REG_SCALE_ONE,
		REG_SCALE_TWO,
		REG_SCALE_THREE
	} reg_idx_t;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [CNT_W-1:0]    count_t;
	typedef logic [SUM_W-1:0]    sum_t;

	// what the last stage produces for one transaction
	typedef struct packed {
		value_t merged;
		count_t count;
		logic   fallback;
	} merge_res_t;

endpackage

/* hw/rtl/hdr_exposure_merge_core.sv */
// Top level of the HDR exposure merge block: register port and four-stage pipeline.
//
// Usage:
//   Input channel: in_valid / in_stall with sample_zero .. sample_three, one
//   pixel channel of each exposure, darkest first, unsigned Q0.16.
//   Output channel: out_valid / out_stall with merged_value (Q2.16),
//   valid_count and used_fallback; exactly one result per input transaction.
//   A transaction moves on a rising edge where valid is high and stall is low.
//   Throughput is one transaction per cycle while out_stall is low; the
//   four registered stages are range checks, scale multipliers, adder tree
//   and divide by the count.
//   When out_stall is held, results stay in the output register and each stage
//   keeps its item; empty stages still fill, so in_stall rises only once every
//   stage holds a transaction.
//   Registers must be written over the APB port only while no transaction is in
//   flight; the block does not enforce it. Reset clears all valid bits and sets
//   the defaults (four exposures, thresholds 131 and 64880, all scales 1.0).
`timescale 1ns / 1ps

module hdr_exposure_merge_core
	import hem_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  sample_t           sample_zero,
	input  sample_t           sample_one,
	input  sample_t           sample_two,
	input  sample_t           sample_three,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output value_t            merged_value,
	output count_t            valid_count,
	output logic              used_fallback
);

	// configuration registers
	count_t                exp_q;
	sample_t               low_q;
	sample_t               high_q;
	logic [SCALE_W-1:0]    scale_q [1:NUM_EXP-1];

	reg_idx_t              reg_idx;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q   <= ExpReset;
			low_q   <= LowReset;
			high_q  <= HighReset;
			for (int i = 1; i < NUM_EXP; i++) begin
				scale_q[i] <= ScaleOne;
			end
		end else if (wr_en) begin
			case (reg_idx)
				REG_EXPOSURES:   exp_q      <= pwdata[CNT_W-1:0];
				REG_LOW_THR:     low_q      <= pwdata[SAMPLE_W-1:0];
				REG_HIGH_THR:    high_q     <= pwdata[SAMPLE_W-1:0];
				REG_SCALE_ONE:   scale_q[1] <= pwdata[SCALE_W-1:0];
				REG_SCALE_TWO:   scale_q[2] <= pwdata[SCALE_W-1:0];
				REG_SCALE_THREE: scale_q[3] <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_EXPOSURES:   prdata = DATA_W'(exp_q);
			REG_LOW_THR:     prdata = DATA_W'(low_q);
			REG_HIGH_THR:    prdata = DATA_W'(high_q);
			REG_SCALE_ONE:   prdata = DATA_W'(scale_q[1]);
			REG_SCALE_TWO:   prdata = DATA_W'(scale_q[2]);
			REG_SCALE_THREE: prdata = DATA_W'(scale_q[3]);
			default:         prdata = '0;
		endcase
	end

	// handshake: a stage takes a new item when it is empty or its successor moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !v_s4 || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: range checks against the thresholds
	sample_t              samp_in [NUM_EXP];
	count_t               n_eff;
	logic [NUM_EXP-1:0]   ok;
	sample_t              samp_s1 [NUM_EXP];
	logic [NUM_EXP-1:0]   ok_s1;

	assign samp_in[0] = sample_zero;
	assign samp_in[1] = sample_one;
	assign samp_in[2] = sample_two;
	assign samp_in[3] = sample_three;

	always_comb begin
		if (exp_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (exp_q > CNT_W'(NUM_EXP)) begin
			n_eff = CNT_W'(NUM_EXP);
		end else begin
			n_eff = exp_q;
		end
	end

	always_comb begin
		logic lo_ok, hi_ok, last;
		for (int i = 0; i < NUM_EXP; i++) begin
			last  = (CNT_W'(i) == n_eff - CNT_W'(1));
			lo_ok = last ? (samp_in[i] != '0) : (samp_in[i] >= low_q);
			hi_ok = (i == 0) ? 1'b1 : (samp_in[i] <= high_q);
			ok[i] = (CNT_W'(i) < n_eff) && lo_ok && hi_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			samp_s1 <= samp_in;
			ok_s1   <= ok;
		end
	end

	// stage 2: scale valid samples one to three, pass sample zero unscaled, truncate to Q2.16
	value_t   term_s2 [NUM_EXP];
	count_t   cnt_s2;
	sample_t  s0_s2;

	always_ff @(posedge clk) begin
		logic [PROD_W-1:0] prod;
		if (rdy_s2) begin
			term_s2[0] <= ok_s1[0] ? VALUE_W'(samp_s1[0]) : '0;
			for (int i = 1; i < NUM_EXP; i++) begin
				prod = {{SCALE_W{1'b0}}, samp_s1[i]} * {{SAMPLE_W{1'b0}}, scale_q[i]};
				term_s2[i] <= ok_s1[i] ? prod[FRAC_W+VALUE_W-1:FRAC_W] : '0;
			end
			cnt_s2 <= CNT_W'($countones(ok_s1));
			s0_s2  <= samp_s1[0];
		end
	end

	// stage 3: add the terms
	sum_t     sum_s3;
	count_t   cnt_s3;
	sample_t  s0_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sum_s3 <= (SUM_W'(term_s2[0]) + SUM_W'(term_s2[1]))
				+ (SUM_W'(term_s2[2]) + SUM_W'(term_s2[3]));
			cnt_s3 <= cnt_s2;
			s0_s3  <= s0_s2;
		end
	end

	// stage 4: divide by the count, output register
	merge_res_t res;
	merge_res_t res_s4;

	hem_div u_div (
		.sum         (sum_s3),
		.count       (cnt_s3),
		.sample_zero (s0_s3),
		.res         (res)
	);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			res_s4 <= res;
		end
	end

	assign out_valid     = v_s4;
	assign merged_value  = res_s4.merged;
	assign valid_count   = res_s4.count;
	assign used_fallback = res_s4.fallback;

endmodule

/* hw/rtl/hem_div.sv */
// Mean of the scaled terms: divide the sum by a count of one to four, or fall back.
`timescale 1ns / 1ps

module hem_div
	import hem_pkg::*;
(
	input  sum_t       sum,
	input  count_t     count,
	input  sample_t    sample_zero,
	output merge_res_t res
);

	logic [SUM_W+RECIP_W-1:0] prod3;
	value_t                   quot;

	assign prod3 = {{RECIP_W{1'b0}}, sum} * {{SUM_W{1'b0}}, Recip3};

	always_comb begin
		case (count)
			3'd1:    quot = sum[VALUE_W-1:0];
			3'd2:    quot = sum[VALUE_W:1];
			3'd3:    quot = prod3[Div3Shift+VALUE_W-1:Div3Shift];
			3'd4:    quot = sum[VALUE_W+1:2];
			default: quot = '0;
		endcase
	end

	always_comb begin
		res.count = count;
		if (count == '0) begin
			res.merged   = VALUE_W'(sample_zero);
			res.fallback = 1'b1;
		end else begin
			res.merged   = quot;
			res.fallback = 1'b0;
		end
	end

endmodule

/* hw/rtl/hem_checker.sv */
// Port-level checks on the HDR exposure merge block, bound to the top level.
`timescale 1ns / 1ps

module hem_checker
	import hem_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   in_stall,
	input logic   out_valid,
	input logic   out_stall,
	input value_t merged_value,
	input count_t valid_count,
	input logic   used_fallback
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(merged_value)
			&& $stable(valid_count) && $stable(used_fallback))
		else $error("result changed while stalled");

	a_fallback_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && used_fallback |-> valid_count == '0)
		else $error("fallback with non-zero count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !used_fallback |-> valid_count != '0
			&& valid_count <= CNT_W'(NUM_EXP))
		else $error("valid count out of range");

	// the input side stalls only while the output side stalls
	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled without output stall");

endmodule

bind hdr_exposure_merge_core hem_checker u_hem_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.merged_value  (merged_value),
	.valid_count   (valid_count),
	.used_fallback (used_fallback)
);
